[rtl/apc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg
// Codes, types and the result record shared by the actuator position
// controller modules.
// ----------------------------------------------------------------------------
package apc_pkg;

    // request kinds
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PULSE = 2'd1;
    localparam logic [1:0] OP_CMD   = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    // relay drive
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_WEST = 2'd1;
    localparam logic [1:0] DIR_EAST = 2'd2;

    // motion states
    localparam logic [2:0] MS_IDLE    = 3'd0;
    localparam logic [2:0] MS_WEST    = 3'd1;
    localparam logic [2:0] MS_EAST    = 3'd2;
    localparam logic [2:0] MS_STOPPED = 3'd3;
    localparam logic [2:0] MS_CHANGE  = 3'd4;
    localparam logic [2:0] MS_REACHED = 3'd5;
    localparam logic [2:0] MS_ERROR   = 3'd6;

    // modes
    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_AUTO  = 2'd1;
    localparam logic [1:0] MODE_MWEST = 2'd2;
    localparam logic [1:0] MODE_MEAST = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    typedef struct packed {
        logic [1:0]         drive;
        logic [2:0]         motion;
        logic [1:0]         mode;
        logic signed [15:0] pos;
        logic signed [15:0] target;
    } t_result;

    typedef struct packed {
        logic [1:0] drive;
        logic [2:0] motion;
        logic       armed;
    } t_status;

endpackage

[rtl/apc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_ctrl
// Controller state and single-pass next-state logic: motion sequencing,
// watchdog / settle timer, position counting and auto stop at target.
// ----------------------------------------------------------------------------
module apc_ctrl #(
    parameter int POS_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_op,
    input  logic [1:0]         i_cmd_mode,
    input  logic signed [15:0] i_value,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output apc_pkg::t_result   o_result,
    output apc_pkg::t_status   o_status
);
    import apc_pkg::*;

    logic [15:0]                 r_timeout;
    logic [2:0]                  r_motion, n_motion;
    logic [2:0]                  r_pending, n_pending;
    logic [1:0]                  r_mode, n_mode;
    logic [1:0]                  r_last_dir, n_last_dir;
    logic [1:0]                  r_drive, n_drive;
    logic signed [POS_WIDTH-1:0] r_pos, n_pos;
    logic signed [POS_WIDTH-1:0] r_target, n_target;
    logic [15:0]                 r_wd_count, n_wd_count;
    logic                        r_wd_armed, n_wd_armed;

    logic signed [31:0] value_ext;
    logic signed [31:0] pos_ext;
    logic signed [31:0] tgt_ext;
    logic [1:0]         cmd;
    logic               is_cmd;

    assign value_ext = 32'(i_value);
    assign is_cmd    = (i_op == OP_CMD) || (i_op == OP_LOAD);
    assign cmd       = (i_op == OP_LOAD) ? MODE_STOP : i_cmd_mode;

    always_comb begin
        n_motion   = r_motion;
        n_pending  = r_pending;
        n_mode     = r_mode;
        n_last_dir = r_last_dir;
        n_drive    = r_drive;
        n_pos      = r_pos;
        n_target   = r_target;
        n_wd_count = r_wd_count;
        n_wd_armed = r_wd_armed;

        if (i_op == OP_TICK) begin
            if (r_wd_armed) begin
                if (r_wd_count <= 16'd1) begin
                    n_wd_count = '0;
                    n_wd_armed = 1'b0;
                    case (r_motion)
                        MS_WEST, MS_EAST: begin
                            n_drive    = DIR_STOP;
                            n_motion   = MS_ERROR;
                            n_last_dir = DIR_STOP;
                            n_wd_count = r_timeout;
                            n_wd_armed = 1'b1;
                        end
                        MS_ERROR: begin
                            n_motion = MS_IDLE;
                        end
                        MS_REACHED, MS_STOPPED, MS_CHANGE: begin
                            // settle over: start whatever was queued
                            n_motion   = r_pending;
                            n_pending  = MS_IDLE;
                            n_last_dir = DIR_STOP;
                            if (r_pending == MS_EAST) begin
                                n_drive    = DIR_EAST;
                                n_last_dir = DIR_EAST;
                            end else if (r_pending == MS_WEST) begin
                                n_drive    = DIR_WEST;
                                n_last_dir = DIR_WEST;
                            end
                            if (r_pending != MS_IDLE) begin
                                n_wd_count = r_timeout;
                                n_wd_armed = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_wd_count = r_wd_count - 16'd1;
                end
            end
        end else if (i_op == OP_PULSE) begin
            if (r_last_dir == DIR_WEST) begin
                n_pos = r_pos + POS_WIDTH'(1);
            end else if (r_last_dir == DIR_EAST) begin
                n_pos = r_pos - POS_WIDTH'(1);
            end
            if (r_motion == MS_WEST || r_motion == MS_EAST) begin
                if (((r_motion == MS_WEST && n_pos >= r_target) ||
                     (r_motion == MS_EAST && n_pos <= r_target)) &&
                    r_mode == MODE_AUTO) begin
                    n_motion = MS_REACHED;
                    n_drive  = DIR_STOP;
                end
                n_wd_count = r_timeout;
                n_wd_armed = 1'b1;
            end
        end else if (is_cmd) begin
            n_mode = cmd;
            if (cmd == MODE_STOP) begin
                n_drive    = DIR_STOP;
                n_pending  = MS_IDLE;
                n_motion   = MS_STOPPED;
                n_wd_count = r_timeout;
                n_wd_armed = 1'b1;
            end else begin
                case (cmd)
                    MODE_AUTO: begin
                        n_target = value_ext[POS_WIDTH-1:0];
                        if (n_motion == MS_REACHED) begin
                            n_motion = MS_STOPPED;
                        end
                        if (n_target > r_pos) begin
                            n_pending = MS_WEST;
                        end else if (n_target < r_pos) begin
                            n_pending = MS_EAST;
                        end else begin
                            n_pending = MS_REACHED;
                        end
                    end
                    MODE_MWEST: n_pending = MS_WEST;
                    default:    n_pending = MS_EAST;
                endcase
                if ((n_motion == MS_EAST && n_pending == MS_WEST) ||
                    (n_motion == MS_WEST && n_pending == MS_EAST)) begin
                    // reversal: stop first, settle, then go
                    n_drive    = DIR_STOP;
                    n_motion   = MS_CHANGE;
                    n_wd_count = r_timeout;
                    n_wd_armed = 1'b1;
                end else if (n_motion == MS_IDLE) begin
                    n_motion  = n_pending;
                    n_pending = MS_IDLE;
                    if (n_motion == MS_EAST) begin
                        n_drive    = DIR_EAST;
                        n_last_dir = DIR_EAST;
                    end else if (n_motion == MS_WEST) begin
                        n_drive    = DIR_WEST;
                        n_last_dir = DIR_WEST;
                    end else begin
                        n_drive = DIR_STOP;
                    end
                    if (n_motion != MS_IDLE) begin
                        n_wd_count = r_timeout;
                        n_wd_armed = 1'b1;
                    end
                end
            end
            if (i_op == OP_LOAD) begin
                n_pos = value_ext[POS_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_motion   <= MS_IDLE;
            r_pending  <= MS_IDLE;
            r_mode     <= MODE_STOP;
            r_last_dir <= DIR_STOP;
            r_drive    <= DIR_STOP;
            r_pos      <= '0;
            r_target   <= '0;
            r_wd_count <= '0;
            r_wd_armed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_accept) begin
                r_motion   <= n_motion;
                r_pending  <= n_pending;
                r_mode     <= n_mode;
                r_last_dir <= n_last_dir;
                r_drive    <= n_drive;
                r_pos      <= n_pos;
                r_target   <= n_target;
                r_wd_count <= n_wd_count;
                r_wd_armed <= n_wd_armed;
            end
        end
    end

    assign pos_ext = 32'(n_pos);
    assign tgt_ext = 32'(n_target);

    assign o_result.drive  = n_drive;
    assign o_result.motion = n_motion;
    assign o_result.mode   = n_mode;
    assign o_result.pos    = pos_ext[15:0];
    assign o_result.target = tgt_ext[15:0];

    assign o_status.drive  = r_drive;
    assign o_status.motion = r_motion;
    assign o_status.armed  = r_wd_armed;

endmodule

[rtl/apc_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_outq
// Two-entry result buffer: output register plus skid entry, so a new
// request is taken while one finished result waits.
// ----------------------------------------------------------------------------
module apc_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  apc_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_full,
    output apc_pkg::t_result o_data
);
    import apc_pkg::*;

    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_q[0] <= r_q[1];
            end else if (i_push) begin
                r_q[0] <= i_data;
            end
        end else if (i_push) begin
            r_q[r_cnt[0]] <= i_data;
        end
    end

endmodule

[rtl/actuator_position_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_position_controller_unit
// Position controller for a two-relay linear actuator with reed pulse input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one request per accepted beat, op
//   selects tick, reed pulse, mode command or position load; i_cmd_mode and
//   i_value qualify commands and loads.
//   Output channel (o_valid / i_stall): one result per request with drive,
//   motion state, mode, position and target after that request.
//   Config channel (i_cfg_valid / o_cfg_ready): writes timeout_ticks; ready
//   is always high. Write only while no results are outstanding.
//   A result is registered when its request is accepted. One request per cycle
//   is sustained while o_stall is low; the state update is one pass of logic
//   between the state registers. A two-entry result buffer lets one request
//   be taken while a result waits; o_stall rises only when both entries are full.
//   Synchronous reset clears the state: idle, stop, position and target 0,
//   timer disarmed, timeout 200, result buffer empty.
// ----------------------------------------------------------------------------
module actuator_position_controller_unit #(
    parameter int POS_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [1:0]         i_cmd_mode,
    input  logic signed [15:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_drive,
    output logic [2:0]         o_motion_state,
    output logic [1:0]         o_mode_now,
    output logic signed [15:0] o_position_now,
    output logic signed [15:0] o_target_now,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import apc_pkg::*;

    logic    accept;
    logic    full;
    t_result result;
    t_result head;
    t_status status;

    assign o_stall     = full;
    assign accept      = i_valid && !full;
    assign o_cfg_ready = 1'b1;

    apc_ctrl #(
        .POS_WIDTH (POS_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_op),
        .i_cmd_mode (i_cmd_mode),
        .i_value    (i_value),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result),
        .o_status   (status)
    );

    apc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_full  (full),
        .o_data  (head)
    );

    assign o_drive        = head.drive;
    assign o_motion_state = head.motion;
    assign o_mode_now     = head.mode;
    assign o_position_now = head.pos;
    assign o_target_now   = head.target;

    // relays run only in a matching run state
    a_drive_matches_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((status.drive == DIR_WEST) == (status.motion == MS_WEST)) &&
        ((status.drive == DIR_EAST) == (status.motion == MS_EAST)))
        else $error("drive and motion state disagree");

    // every non-idle state is timed
    a_timer_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.motion != MS_IDLE) |-> status.armed)
        else $error("timer not armed outside idle");

    // an accepted request always yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted request left no result");

endmodule

[verif/actuator_position_controller_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_position_controller_unit_test
// Self-checking bench for the actuator position controller. A tracker class
// keeps its own copy of the relay, motion, mode, position and watchdog state,
// predicts the report for every accepted request and compares each accepted
// result field by field. Directed requests cover wrap, reversal, watchdog
// error and target reach; random command/pulse/tick episodes follow under
// several timeout settings and idle/stall profiles.
// ----------------------------------------------------------------------------
module actuator_position_controller_unit_test;
    import apc_pkg::*;

    class actuator_tracker;
        logic [15:0] timeout;
        logic [2:0]  motion;
        logic [2:0]  pend_motion;
        logic [1:0]  mode;
        logic [1:0]  last_dir;
        logic [1:0]  drive;
        logic [15:0] pos;
        logic [15:0] target;
        logic [15:0] wd_count;
        bit          wd_armed;
        t_result     reports_q[$];
        int          errors;

        function new();
            timeout     = TIMEOUT_RESET;
            motion      = MS_IDLE;
            pend_motion = MS_IDLE;
            mode        = MODE_STOP;
            last_dir    = DIR_STOP;
            drive       = DIR_STOP;
            pos         = '0;
            target      = '0;
            wd_count    = '0;
            wd_armed    = 1'b0;
            errors      = 0;
        endfunction

        function void set_timeout(logic [15:0] ticks);
            timeout = ticks;
        endfunction

        function int pending();
            return reports_q.size();
        endfunction

        function void arm_watchdog();
            wd_count = timeout;
            wd_armed = 1'b1;
        endfunction

        function void run_relays(logic [1:0] dir);
            drive = dir;
            if (dir != DIR_STOP) begin
                last_dir = dir;
                motion   = (dir == DIR_WEST) ? MS_WEST : MS_EAST;
            end
        endfunction

        // start whatever motion was waiting, from idle or after a settle delay
        function void start_pending();
            motion      = pend_motion;
            pend_motion = MS_IDLE;
            if (motion == MS_EAST)
                run_relays(DIR_EAST);
            else if (motion == MS_WEST)
                run_relays(DIR_WEST);
            if (motion != MS_IDLE)
                arm_watchdog();
        endfunction

        function void apply_mode(logic [1:0] new_mode, logic [15:0] val);
            mode = new_mode;
            if (mode == MODE_STOP) begin
                run_relays(DIR_STOP);
                pend_motion = MS_IDLE;
                motion      = MS_STOPPED;
                arm_watchdog();
                return;
            end
            case (mode)
                MODE_AUTO: begin
                    target = val;
                    if (motion == MS_REACHED)
                        motion = MS_STOPPED;
                    if ($signed(target) > $signed(pos))
                        pend_motion = MS_WEST;
                    else if ($signed(target) < $signed(pos))
                        pend_motion = MS_EAST;
                    else
                        pend_motion = MS_REACHED;
                end
                MODE_MWEST: pend_motion = MS_WEST;
                default:    pend_motion = MS_EAST;
            endcase
            if ((motion == MS_EAST && pend_motion == MS_WEST) ||
                (motion == MS_WEST && pend_motion == MS_EAST)) begin
                run_relays(DIR_STOP);
                motion = MS_CHANGE;
                arm_watchdog();
            end else if (motion == MS_IDLE) begin
                drive = DIR_STOP;
                start_pending();
            end
        endfunction

        function void watchdog_expired();
            case (motion)
                MS_WEST, MS_EAST: begin
                    drive    = DIR_STOP;
                    motion   = MS_ERROR;
                    last_dir = DIR_STOP;
                    arm_watchdog();
                end
                MS_ERROR: motion = MS_IDLE;
                MS_REACHED, MS_STOPPED, MS_CHANGE: begin
                    last_dir = DIR_STOP;
                    start_pending();
                end
                default: ;
            endcase
        endfunction

        function void reed_pulse();
            if (last_dir == DIR_WEST)
                pos = pos + 16'd1;
            else if (last_dir == DIR_EAST)
                pos = pos - 16'd1;
            if (motion == MS_WEST || motion == MS_EAST) begin
                if (((motion == MS_WEST && $signed(pos) >= $signed(target)) ||
                     (motion == MS_EAST && $signed(pos) <= $signed(target))) &&
                    mode == MODE_AUTO) begin
                    motion = MS_REACHED;
                    run_relays(DIR_STOP);
                end
                arm_watchdog();
            end
        endfunction

        function void note_request(logic [1:0] op, logic [1:0] cmd, logic [15:0] val);
            t_result rep;
            case (op)
                OP_TICK: begin
                    if (wd_armed) begin
                        if (wd_count <= 16'd1) begin
                            wd_count = '0;
                            wd_armed = 1'b0;
                            watchdog_expired();
                        end else begin
                            wd_count = wd_count - 16'd1;
                        end
                    end
                end
                OP_PULSE: reed_pulse();
                OP_CMD:   apply_mode(cmd, val);
                default: begin
                    apply_mode(MODE_STOP, '0);
                    pos = val;
                end
            endcase
            rep.drive  = drive;
            rep.motion = motion;
            rep.mode   = mode;
            rep.pos    = pos;
            rep.target = target;
            reports_q.push_back(rep);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                if (errors < 40)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (reports_q.size() == 0) begin
                if (errors < 40)
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, got);
                errors++;
                return;
            end
            want = reports_q.pop_front();
            compare_field("drive", want.drive, got.drive);
            compare_field("motion_state", want.motion, got.motion);
            compare_field("mode_now", want.mode, got.mode);
            compare_field("position_now", want.pos, got.pos);
            compare_field("target_now", want.target, got.target);
        endfunction
    endclass

    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 205;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_op;
    logic [1:0]         i_cmd_mode;
    logic signed [15:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_drive;
    logic [2:0]         o_motion_state;
    logic [1:0]         o_mode_now;
    logic signed [15:0] o_position_now;
    logic signed [15:0] o_target_now;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data;

    actuator_tracker tracker;
    int src_idle_pct;
    int sink_stall_pct;
    int requests_sent;

    logic [15:0] phase_timeout [PHASES] =
        '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd200, 16'd2, 16'd5, 16'd8};

    actuator_position_controller_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_cmd_mode     (i_cmd_mode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive        (o_drive),
        .o_motion_state (o_motion_state),
        .o_mode_now     (o_mode_now),
        .o_position_now (o_position_now),
        .o_target_now   (o_target_now),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // results first so a request taken on this edge never meets its own result
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.drive  = o_drive;
                got.motion = o_motion_state;
                got.mode   = o_mode_now;
                got.pos    = o_position_now;
                got.target = o_target_now;
                tracker.check_report(got);
            end
            if (i_valid && !o_stall)
                tracker.note_request(i_op, i_cmd_mode, i_value);
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_timeout(i_cfg_data);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [1:0] cmd,
                                input logic [15:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_cmd_mode <= cmd;
        i_value    <= val;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // a mode command followed by a run of pulses and ticks, with an occasional command or load, near the target
    task automatic run_episode();
        logic [15:0] goal;
        int          steps;
        int          pick;
        goal = tracker.pos + 16'($urandom_range(16)) - 16'd8;
        if ($urandom_range(7) == 0)
            goal = 16'($urandom);
        send_request(OP_CMD, 2'($urandom_range(3)), goal);
        steps = $urandom_range(1, 14);
        repeat (steps) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_request(OP_PULSE, 2'($urandom), 16'($urandom));
            else if (pick < 90)
                send_request(OP_TICK, 2'($urandom), 16'($urandom));
            else if (pick < 95)
                send_request(OP_CMD, 2'($urandom), tracker.pos + 16'($urandom_range(4)) - 16'd2);
            else
                send_request(OP_LOAD, 2'($urandom), tracker.target + 16'($urandom_range(6)) - 16'd3);
        end
        // let the watchdog run out now and then
        if ($urandom_range(2) == 0 && tracker.timeout <= 16'd8)
            repeat (int'(tracker.timeout) + 1)
                send_request(OP_TICK, 2'($urandom), 16'($urandom));
    endtask

    initial begin
        int wait_cycles;
        int phase_end;
        tracker        = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        requests_sent  = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= OP_TICK;
        i_cmd_mode  <= MODE_STOP;
        i_value     <= '0;
        i_stall     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_timeout(16'd2);
        // tick and pulse while nothing is armed or driven
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_PULSE, MODE_STOP, 16'h0000);
        send_request(OP_LOAD, MODE_AUTO, 16'h7fff);
        send_request(OP_CMD, MODE_MWEST, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        // position wraps from the top to the bottom
        send_request(OP_PULSE, MODE_STOP, 16'h0000);
        send_request(OP_CMD, MODE_MEAST, 16'hffff);
        send_request(OP_TICK, MODE_MEAST, 16'hffff);
        send_request(OP_TICK, MODE_MEAST, 16'hffff);
        send_request(OP_PULSE, MODE_MEAST, 16'hffff);
        // no pulse in time: error state
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_CMD, MODE_AUTO, 16'h8000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_CMD, MODE_AUTO, 16'h8000);
        send_request(OP_PULSE, MODE_STOP, 16'h0000);
        send_request(OP_LOAD, MODE_MWEST, 16'h8001);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_CMD, MODE_AUTO, 16'h8000);
        send_request(OP_PULSE, MODE_STOP, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        send_request(OP_TICK, MODE_STOP, 16'h0000);
        // target equal to position from idle
        send_request(OP_CMD, MODE_AUTO, 16'h8000);
        send_request(OP_CMD, MODE_STOP, 16'h0000);

        for (int p = 0; p < PHASES; p++) begin
            write_timeout(phase_timeout[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            phase_end = requests_sent + PHASE_REQS;
            while (requests_sent < phase_end) begin
                if ($urandom_range(9) < 7)
                    run_episode();
                else
                    send_request(2'($urandom), 2'($urandom), 16'($urandom));
            end
        end

        i_valid <= 1'b0;
        wait_cycles = 0;
        while (tracker.pending() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
